FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/iegc_pkg.sv
// Package: types and constants of the interleaved exp-Golomb codec.
`default_nettype none
package iegc_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int CODE_WIDTH      = 64;
    localparam int LEN_WIDTH       = 7;
    localparam int OUT_VALUE_WIDTH = 32;
    localparam int T_WIDTH         = $clog2(VALUE_WIDTH);
    localparam int FLAG_COUNT      = CODE_WIDTH / 2;
    localparam int K_WIDTH         = $clog2(FLAG_COUNT);
    localparam int IDX_WIDTH       = $clog2(CODE_WIDTH);

    typedef enum logic [1:0] {
        OP_ENC_U = 2'd0,
        OP_ENC_S = 2'd1,
        OP_DEC_U = 2'd2,
        OP_DEC_S = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [31:0]            value_in;
        logic [CODE_WIDTH-1:0]  code_in;
        logic [LEN_WIDTH-1:0]   code_in_length;
    } cmd_t;

    typedef struct packed {
        logic [CODE_WIDTH-1:0]      code_out;
        logic [LEN_WIDTH-1:0]       code_out_length;
        logic [OUT_VALUE_WIDTH-1:0] value_out;
        logic                       error;
    } result_t;

endpackage
`default_nettype wire

FILE: design/iegc_core.sv
// Combinational encode/decode datapath of the interleaved exp-Golomb codec.
`default_nettype none
module iegc_core
    import iegc_pkg::*;
(
    input  wire cmd_t cmd,
    output result_t   result
);

    // ---------------- encode ----------------
    logic [VALUE_WIDTH-1:0] val;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] enc_v;
    logic [T_WIDTH-1:0]     enc_t;
    logic [VALUE_WIDTH-1:0] enc_body;
    logic [CODE_WIDTH-1:0]  enc_code;
    logic [LEN_WIDTH-1:0]   enc_len;
    logic                   enc_u_err;
    logic                   enc_s_err;

    assign val      = cmd.value_in[VALUE_WIDTH-1:0];
    assign neg      = val[VALUE_WIDTH-1];
    assign mag      = (cmd.opcode == OP_ENC_S && neg) ? VALUE_WIDTH'(~val + 1'b1) : val;
    assign enc_v    = VALUE_WIDTH'(mag + 1'b1);
    assign enc_body = enc_v ^ (VALUE_WIDTH'(1) << enc_t);
    assign enc_len  = LEN_WIDTH'({enc_t, 1'b1});

    assign enc_u_err = (val == {VALUE_WIDTH{1'b1}});
    assign enc_s_err = (val == {1'b1, {(VALUE_WIDTH-1){1'b0}}});

    // Leading one of value+1.
    always_comb
    begin
        enc_t = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (enc_v[i])
            begin
                enc_t = T_WIDTH'(i);
            end
        end
    end

    // Interleave: data bit k lands at 2k+1, zero flags at even places, stop bit at 0.
    always_comb
    begin
        enc_code    = '0;
        enc_code[0] = 1'b1;
        for (int k = 0; k < VALUE_WIDTH-1; k++)
        begin
            enc_code[2*k+1] = enc_body[k];
        end
    end

    // ---------------- decode ----------------
    logic [LEN_WIDTH-1:0]       n_clamp;
    logic [CODE_WIDTH-1:0]      w;
    logic [K_WIDTH-1:0]         dec_k;
    logic                       dec_found;
    logic [FLAG_COUNT-2:0]      dec_data;
    logic [FLAG_COUNT-1:0]      dec_v;
    logic [FLAG_COUNT-1:0]      dec_m;
    logic                       over_u;
    logic                       over_s;
    logic                       sign_ok;
    logic [IDX_WIDTH-1:0]       sign_idx;
    logic                       sign_bit;
    logic [OUT_VALUE_WIDTH-1:0] dec_ext;

    assign n_clamp = (cmd.code_in_length > LEN_WIDTH'(CODE_WIDTH))
                   ? LEN_WIDTH'(CODE_WIDTH) : cmd.code_in_length;
    // Left-align the valid bits; stray bits above the length fall off the top.
    assign w = cmd.code_in << (LEN_WIDTH'(CODE_WIDTH) - n_clamp);

    // First 1 flag from the top; flags sit at even offsets from the MSB.
    always_comb
    begin
        dec_k     = '0;
        dec_found = 1'b0;
        for (int j = FLAG_COUNT-1; j >= 0; j--)
        begin
            if (w[CODE_WIDTH-1-2*j])
            begin
                dec_k     = K_WIDTH'(j);
                dec_found = 1'b1;
            end
        end
    end

    // Gather the data bits, first one at the top.
    always_comb
    begin
        dec_data = '0;
        for (int j = 0; j < FLAG_COUNT-1; j++)
        begin
            dec_data[FLAG_COUNT-2-j] = w[CODE_WIDTH-2-2*j];
        end
    end

    assign dec_v   = (FLAG_COUNT'(1) << dec_k)
                   | FLAG_COUNT'(dec_data >> (K_WIDTH'(FLAG_COUNT-1) - dec_k));
    assign dec_m   = FLAG_COUNT'(dec_v - 1'b1);
    assign over_u  = (dec_m >> VALUE_WIDTH) != '0;
    assign over_s  = (dec_m >> (VALUE_WIDTH-1)) != '0;
    assign sign_ok = n_clamp >= (LEN_WIDTH'({dec_k, 1'b0}) + LEN_WIDTH'(2));
    assign sign_idx = IDX_WIDTH'(CODE_WIDTH-2) - IDX_WIDTH'({dec_k, 1'b0});
    assign sign_bit = w[sign_idx];
    assign dec_ext  = OUT_VALUE_WIDTH'(dec_m);

    // ---------------- result ----------------
    always_comb
    begin
        result = '0;
        case (cmd.opcode)
            OP_ENC_U:
            begin
                if (enc_u_err)
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    result.code_out        = enc_code;
                    result.code_out_length = enc_len;
                end
            end
            OP_ENC_S:
            begin
                if (val == '0)
                begin
                    result.code_out        = CODE_WIDTH'(1);
                    result.code_out_length = LEN_WIDTH'(1);
                end
                else if (enc_s_err)
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    result.code_out        = (enc_code << 1) | CODE_WIDTH'(neg);
                    result.code_out_length = LEN_WIDTH'(enc_len + 1'b1);
                end
            end
            OP_DEC_U:
            begin
                if (!dec_found || over_u)
                begin
                    result.error = 1'b1;
                end
                else
                begin
                    result.value_out = dec_ext;
                end
            end
            OP_DEC_S:
            begin
                if (!dec_found || over_s)
                begin
                    result.error = 1'b1;
                end
                else if (dec_m != '0)
                begin
                    if (!sign_ok)
                    begin
                        result.error = 1'b1;
                    end
                    else
                    begin
                        result.value_out = sign_bit ? OUT_VALUE_WIDTH'(~dec_ext + 1'b1)
                                                    : dec_ext;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/interleaved_exp_golomb_codec.sv
// Top level of the interleaved exp-Golomb codec: command register, datapath, result register.
//
// Usage:
//   - Command channel: drive cmd and raise start; a beat is taken at each rising
//     edge where start is high and busy is low. busy never rises, so a new
//     command may be issued every cycle.
//   - cmd.opcode picks encode unsigned, encode signed, decode unsigned or decode
//     signed. Decode reads the low code_in_length bits of a right-aligned word,
//     highest valid bit first.
//   - Result channel: done pulses for exactly one cycle per command, with the
//     result beat on the result port; the receiver takes it in that cycle and
//     cannot hold it off.
//   - A taken command waits in the command register, passes the datapath and
//     lands in the result register with done. Throughput is one command per
//     cycle, set by the single datapath pass between the two registers.
//   - Errors (out-of-range value, malformed or truncated code) raise
//     result.error and zero every other result field.
//   - Reset (rst_n low, asynchronous) drops any command in flight; done is low
//     until a new command arrives. No configuration and no state beyond the two
//     pipeline registers.
`default_nettype none
`include "assert_macros.svh"
module interleaved_exp_golomb_codec
    import iegc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result
);

    logic    accept;
    logic    valid_reg;
    logic    valid_next;
    logic    done_reg;
    logic    done_next;
    cmd_t    cmd_reg;
    cmd_t    cmd_next;
    result_t result_reg;
    result_t result_next;
    result_t core_result;
    logic    fields_clear;
    logic    code_beat;

    // The pipeline never backs up: the receiver cannot stall, so hold busy low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next  = accept;
    assign done_next   = valid_reg;
    assign cmd_next    = accept ? cmd : cmd_reg;
    assign result_next = valid_reg ? core_result : result_reg;

    // Control: one valid bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Payload: capture the command beat, then the computed result.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    iegc_core u_core (
        .cmd    (cmd_reg),
        .result (core_result)
    );

    assign done   = done_reg;
    assign result = result_reg;

    assign fields_clear = (result.code_out == '0) && (result.code_out_length == '0)
                          && (result.value_out == '0);
    assign code_beat    = done && (result.code_out_length != '0);

    `ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, valid_reg)
    `ASSERT_NEXT(a_done_follows, clk, rst_n, valid_reg, done)
    `ASSERT_NEXT(a_idle_quiet, clk, rst_n, !valid_reg, !done)
    `ASSERT_IMPLIES(a_error_clears, clk, rst_n, done && result.error, fields_clear)
    `ASSERT_IMPLIES(a_one_kind, clk, rst_n, code_beat, result.value_out == '0)

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the interleaved exp-Golomb codec.
`timescale 1ns / 1ps

module tb;
    import iegc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 750;
    localparam int SETTLE_CYCLES  = 6;

    // Tracks code words in flight: predicts each result, holds the
    // expectations in order and checks every result beat against them.
    class codeword_tracker;
        result_t outstanding_results[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Build 2t+1 interleaved bits for magnitude m, where t is the leading
        // one of m+1: a 0 flag ahead of each lower bit, then the closing 1.
        function void encode_magnitude(input logic [63:0] m, output logic [63:0] code,
                                       output int unsigned len);
            logic [63:0] v;
            logic [63:0] acc;
            int          t;
            v   = m + 64'd1;
            t   = 0;
            acc = '0;
            for (int i = 1; i < 64; i++)
                if (v[i])
                    t = i;
            for (int i = t; i > 0; i--)
                acc = {acc[61:0], 1'b0, v[i-1]};
            code = {acc[62:0], 1'b1};
            len  = 2 * t + 1;
        endfunction

        function result_t predict_codec(cmd_t c);
            result_t     r;
            logic [63:0] wm, sbit, val, mag, cin, vacc, code, vout;
            int unsigned len;
            int          n, pos;
            bit          err, ok, stop, neg;
            wm   = (64'd1 << VALUE_WIDTH) - 64'd1;
            sbit = 64'd1 << (VALUE_WIDTH - 1);
            val  = {32'd0, c.value_in} & wm;
            code = '0;
            len  = 0;
            vout = '0;
            err  = 0;
            case (c.opcode)
                OP_ENC_U:
                begin
                    if (val == wm)
                        err = 1;
                    else
                        encode_magnitude(val, code, len);
                end
                OP_ENC_S:
                begin
                    if (val == 0)
                    begin
                        code = 64'd1;
                        len  = 1;
                    end
                    else if (val == sbit)
                        err = 1;
                    else
                    begin
                        neg = (val & sbit) != 0;
                        mag = neg ? (((~val) + 64'd1) & wm) : val;
                        encode_magnitude(mag, code, len);
                        code = {code[62:0], neg};
                        len  = len + 1;
                    end
                end
                default:
                begin
                    // Clip the length, drop stray bits, then walk flag/data pairs
                    // down from the top of the valid bits.
                    n = c.code_in_length;
                    if (n > 64)
                        n = 64;
                    cin = c.code_in;
                    if (n < 64)
                        cin &= (64'd1 << n) - 64'd1;
                    pos  = n;
                    vacc = 64'd1;
                    ok   = 1;
                    stop = 0;
                    while (ok && !stop)
                    begin
                        if (pos == 0)
                            ok = 0;
                        else
                        begin
                            pos--;
                            if (cin[pos])
                                stop = 1;
                            else if (pos == 0)
                                ok = 0;
                            else
                            begin
                                pos--;
                                vacc = {vacc[62:0], cin[pos]};
                            end
                        end
                    end
                    if (!ok)
                        err = 1;
                    else
                    begin
                        mag = vacc - 64'd1;
                        if (c.opcode == OP_DEC_U)
                        begin
                            if (mag > wm)
                                err = 1;
                            else
                                vout = mag;
                        end
                        else if (mag > sbit - 64'd1)
                            err = 1;
                        else if (mag != 0)
                        begin
                            // Nonzero magnitude needs its sign bit right after the code.
                            if (pos == 0)
                                err = 1;
                            else
                            begin
                                pos--;
                                vout = cin[pos] ? (((~mag) + 64'd1) & 64'hFFFF_FFFF) : mag;
                            end
                        end
                    end
                end
            endcase
            if (err)
            begin
                code = '0;
                len  = 0;
                vout = '0;
            end
            r.code_out        = code;
            r.code_out_length = len[LEN_WIDTH-1:0];
            r.value_out       = vout[31:0];
            r.error           = err;
            return r;
        endfunction

        function void note_command(cmd_t c);
            outstanding_results.push_back(predict_codec(c));
        endfunction

        function int pending_count();
            return outstanding_results.size();
        endfunction

        task check_result(result_t got);
            result_t exp;
            if (outstanding_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending: %p", got));
                return;
            end
            exp = outstanding_results.pop_front();
            if (got.code_out !== exp.code_out)
                report_mismatch($sformatf("code_out got %h want %h", got.code_out,
                                          exp.code_out));
            if (got.code_out_length !== exp.code_out_length)
                report_mismatch($sformatf("code_out_length got %0d want %0d",
                                          got.code_out_length, exp.code_out_length));
            if (got.value_out !== exp.value_out)
                report_mismatch($sformatf("value_out got %h want %h", got.value_out,
                                          exp.value_out));
            if (got.error !== exp.error)
                report_mismatch($sformatf("error got %b want %b", got.error, exp.error));
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    cmd_t            cmd;
    logic            done;
    result_t         result;
    codeword_tracker tracker;
    int              cycle_count;

    interleaved_exp_golomb_codec u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: the receiver cannot stall, so take every done beat as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(result);
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Fields an operation ignores still get random content so every bit toggles.
    function automatic cmd_t make_encode(opcode_t op, logic [31:0] v);
        cmd_t c;
        c.opcode         = op;
        c.value_in       = v;
        c.code_in        = random_word();
        c.code_in_length = LEN_WIDTH'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic cmd_t make_decode(opcode_t op, logic [63:0] code, int len);
        cmd_t c;
        c.opcode         = op;
        c.value_in       = $urandom;
        c.code_in        = code;
        c.code_in_length = LEN_WIDTH'(len);
        return c;
    endfunction

    // Spread values over every code length, with the extremes showing up often.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 4)
            return $urandom;
        if (sel < 12)
            return $urandom >> $urandom_range(0, 31);
        if (sel < 14)
            return $urandom_range(0, 7);
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'hFFFF_FFFE;
            default: return 32'h8000_0001;
        endcase
    endfunction

    // A real code word with random trailing bits, now and then cut short,
    // with junk above the valid bits, or with a length past 64.
    function automatic cmd_t build_decode(opcode_t op);
        result_t     src;
        logic [63:0] code;
        int          len, trailing, keep;
        src  = tracker.predict_codec(make_encode($urandom_range(0, 1) ? OP_ENC_S : OP_ENC_U,
                                                 pick_value()));
        code = src.code_out;
        len  = src.code_out_length;
        trailing = $urandom_range(0, 64 - len);
        code = (code << trailing) | (random_word() & ((64'd1 << trailing) - 64'd1));
        len  = len + trailing;
        if ($urandom_range(0, 7) == 0 && len > 0)
        begin
            keep = $urandom_range(0, len - 1);
            code = code >> (len - keep);
            len  = keep;
        end
        if (len < 64 && $urandom_range(0, 1))
            code |= random_word() << len;
        if (len == 64 && $urandom_range(0, 1))
            len = $urandom_range(65, 127);
        return make_decode(op, code, len);
    endfunction

    function automatic cmd_t random_command();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return make_encode($urandom_range(0, 1) ? OP_ENC_S : OP_ENC_U, pick_value());
        if (sel < 85)
            return build_decode($urandom_range(0, 1) ? OP_DEC_S : OP_DEC_U);
        return make_decode($urandom_range(0, 1) ? OP_DEC_S : OP_DEC_U,
                           random_word() >> $urandom_range(0, 63), $urandom_range(0, 127));
    endfunction

    // Present one command beat at the falling edge and hold it until taken.
    task automatic send_command(cmd_t c);
        @(negedge clk);
        start = 1'b1;
        cmd   = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(c);
    endtask

    // Drop start for a few cycles; the bus carries junk that must be ignored.
    task automatic idle_cycles(int count);
        repeat (count)
        begin
            @(negedge clk);
            start = 1'b0;
            cmd   = cmd_t'({random_word(), random_word()});
        end
    endtask

    // Hold off the sender until every outstanding result beat has come back.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (tracker.pending_count() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        cmd_t        directed[$];
        result_t     longest, widest_signed, largest_positive, overflow_src;
        int          sent, burst;

        tracker     = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        longest          = tracker.predict_codec(make_encode(OP_ENC_U, 32'hFFFF_FFFE));
        widest_signed    = tracker.predict_codec(make_encode(OP_ENC_S, 32'h8000_0001));
        largest_positive = tracker.predict_codec(make_encode(OP_ENC_S, 32'h7FFF_FFFF));
        overflow_src     = tracker.predict_codec(make_encode(OP_ENC_U, 32'h8000_0000));

        // Encode extremes, including all ones unsigned and the signed minimum.
        directed.push_back(make_encode(OP_ENC_U, 32'h0000_0000));
        directed.push_back(make_encode(OP_ENC_U, 32'h0000_0001));
        directed.push_back(make_encode(OP_ENC_U, 32'hFFFF_FFFE));
        directed.push_back(make_encode(OP_ENC_U, 32'hFFFF_FFFF));
        directed.push_back(make_encode(OP_ENC_S, 32'h0000_0000));
        directed.push_back(make_encode(OP_ENC_S, 32'h0000_0001));
        directed.push_back(make_encode(OP_ENC_S, 32'hFFFF_FFFF));
        directed.push_back(make_encode(OP_ENC_S, 32'h7FFF_FFFF));
        directed.push_back(make_encode(OP_ENC_S, 32'h8000_0000));
        directed.push_back(make_encode(OP_ENC_S, 32'h8000_0001));
        // Decode: zero, empty word, 0 flag with no data bit, no closing flag.
        directed.push_back(make_decode(OP_DEC_U, 64'd1, 1));
        directed.push_back(make_decode(OP_DEC_U, 64'd0, 0));
        directed.push_back(make_decode(OP_DEC_U, 64'd0, 1));
        directed.push_back(make_decode(OP_DEC_U, 64'd0, 64));
        // Longest unsigned code with one trailing bit, then with a length past 64.
        directed.push_back(make_decode(OP_DEC_U, {longest.code_out[62:0], 1'b1}, 64));
        directed.push_back(make_decode(OP_DEC_U, {longest.code_out[62:0], 1'b0}, 127));
        // Junk above the valid bits, then trailing bits below the code.
        directed.push_back(make_decode(OP_DEC_U, 64'hFFFF_FFFF_FFFF_FFF3, 3));
        directed.push_back(make_decode(OP_DEC_U, 64'b10110, 5));
        // Signed decode: two words with no closing flag, then negative zero.
        directed.push_back(make_decode(OP_DEC_S, 64'b010, 3));
        directed.push_back(make_decode(OP_DEC_S, 64'b0101, 4));
        directed.push_back(make_decode(OP_DEC_S, 64'b11, 2));
        // Magnitude just past the signed range, then the widest legal codes.
        directed.push_back(make_decode(OP_DEC_S, {overflow_src.code_out[62:0], 1'b0}, 64));
        directed.push_back(make_decode(OP_DEC_S, widest_signed.code_out, 64));
        directed.push_back(make_decode(OP_DEC_S, largest_positive.code_out, 64));

        // Directed beats go back to back.
        foreach (directed[i])
            send_command(directed[i]);
        drain_results();

        // Random part: bursts of random length, sometimes with no gap at all.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < RANDOM_ITEMS)
            begin
                send_command(random_command());
                sent++;
                burst--;
                if (sent == RANDOM_ITEMS / 2)
                    drain_results();
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end

        drain_results();
        // Let a stray done beat show itself before closing out.
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
